[hdl/sorted_price_table_unit_macros.svh]
// ----------------------------------------------------------------------------
// Sorted price table assertion macros
// Clocked assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRICE_TABLE_UNIT_MACROS_SVH
`define SORTED_PRICE_TABLE_UNIT_MACROS_SVH

// checked on every clock edge outside reset
`define SPT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define SPT_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/spt_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted price table package
// Sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spt_pkg;

	localparam int DEPTH       = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int CMD_W       = 3;
	localparam int TAG_W       = 16;
	localparam int PRICE_W     = 32;
	localparam int POS_W       = 4;
	localparam int STATUS_W    = 2;
	localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int ENTRY_W     = TAG_W + PRICE_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 3'd0,
		CMD_DELETE = 3'd1,
		CMD_MIN    = 3'd2,
		CMD_MAX    = 3'd3,
		CMD_DUMP   = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_CMP,
		S_INS_PUT,
		S_DEL_CAP,
		S_DEL_SH,
		S_DEL_DONE,
		S_RD_OUT,
		S_DMP_OUT,
		S_ERR_FULL,
		S_ERR_EMPTY,
		S_ERR_NFND
	} state_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_TOP,
		IDX_POS,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_NEW,
		RES_HOLD,
		RES_RDATA
	} res_src_t;

	// controller -> datapath
	typedef struct packed {
		logic     cap_in;
		idx_op_t  idx_op;
		logic     rd_en;
		logic     rd_p1;
		logic     wr_en;
		logic     wr_p1;
		logic     wr_new;
		logic     hold_cap;
		cnt_op_t  cnt_op;
		logic     res_load;
		res_src_t res_src;
		status_t  res_status;
		logic     res_last;
	} spt_ctl_t;

	// datapath -> controller
	typedef struct packed {
		cmd_t cmd;
		logic cnt_zero;
		logic cnt_full;
		logic pos_oob;
		logic ge;
		logic idx_zero;
		logic del_tail;
		logic del_more;
		logic dump_last;
		logic out_free;
	} spt_stat_t;

endpackage

[hdl/spt_ram.sv]
// ----------------------------------------------------------------------------
// Sorted price table RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spt_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                             wr_data,
	input  logic                                         rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                             rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/spt_ctrl.sv]
// ----------------------------------------------------------------------------
// Sorted price table controller
// Command sequencer: decodes an item and steps the datapath through it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spt_ctrl
	import spt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  spt_stat_t st,
	output spt_ctl_t  ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		ctl.cap_in     = 1'b0;
		ctl.idx_op     = IDX_HOLD;
		ctl.rd_en      = 1'b0;
		ctl.rd_p1      = 1'b0;
		ctl.wr_en      = 1'b0;
		ctl.wr_p1      = 1'b0;
		ctl.wr_new     = 1'b0;
		ctl.hold_cap   = 1'b0;
		ctl.cnt_op     = CNT_HOLD;
		ctl.res_load   = 1'b0;
		ctl.res_src    = RES_ZERO;
		ctl.res_status = STAT_OK;
		ctl.res_last   = 1'b1;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.cap_in = 1'b1;
					state_d    = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (st.cmd)
					CMD_INSERT: begin
						if (st.cnt_full) begin
							state_d = S_ERR_FULL;
						end else if (st.cnt_zero) begin
							ctl.idx_op = IDX_ZERO;
							state_d    = S_INS_PUT;
						end else begin
							// scan down from the tail, shifting up as we go
							ctl.idx_op = IDX_TOP;
							ctl.rd_en  = 1'b1;
							state_d    = S_INS_CMP;
						end
					end
					CMD_DELETE: begin
						if (st.cnt_zero) begin
							state_d = S_ERR_EMPTY;
						end else if (st.pos_oob) begin
							state_d = S_ERR_NFND;
						end else begin
							ctl.idx_op = IDX_POS;
							ctl.rd_en  = 1'b1;
							state_d    = S_DEL_CAP;
						end
					end
					CMD_MIN: begin
						if (st.cnt_zero) begin
							state_d = S_ERR_EMPTY;
						end else begin
							ctl.idx_op = IDX_ZERO;
							ctl.rd_en  = 1'b1;
							state_d    = S_RD_OUT;
						end
					end
					CMD_MAX: begin
						if (st.cnt_zero) begin
							state_d = S_ERR_EMPTY;
						end else begin
							ctl.idx_op = IDX_TOP;
							ctl.rd_en  = 1'b1;
							state_d    = S_RD_OUT;
						end
					end
					CMD_DUMP: begin
						if (st.cnt_zero) begin
							state_d = S_ERR_EMPTY;
						end else begin
							ctl.idx_op = IDX_ZERO;
							ctl.rd_en  = 1'b1;
							state_d    = S_DMP_OUT;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_INS_CMP: begin
				if (st.ge) begin
					ctl.wr_en = 1'b1;
					ctl.wr_p1 = 1'b1;
					if (st.idx_zero) begin
						state_d = S_INS_PUT;
					end else begin
						ctl.idx_op = IDX_DEC;
						ctl.rd_en  = 1'b1;
					end
				end else begin
					// new entry goes just above the lower price
					ctl.idx_op = IDX_INC;
					state_d    = S_INS_PUT;
				end
			end
			S_INS_PUT: begin
				if (st.out_free) begin
					ctl.wr_en    = 1'b1;
					ctl.wr_new   = 1'b1;
					ctl.res_load = 1'b1;
					ctl.res_src  = RES_NEW;
					ctl.cnt_op   = CNT_INC;
					state_d      = S_IDLE;
				end
			end
			S_DEL_CAP: begin
				ctl.hold_cap = 1'b1;
				if (st.del_tail) begin
					state_d = S_DEL_DONE;
				end else begin
					ctl.rd_en = 1'b1;
					ctl.rd_p1 = 1'b1;
					state_d   = S_DEL_SH;
				end
			end
			S_DEL_SH: begin
				ctl.wr_en = 1'b1;
				if (st.del_more) begin
					ctl.idx_op = IDX_INC;
					ctl.rd_en  = 1'b1;
					ctl.rd_p1  = 1'b1;
				end else begin
					state_d = S_DEL_DONE;
				end
			end
			S_DEL_DONE: begin
				if (st.out_free) begin
					ctl.res_load = 1'b1;
					ctl.res_src  = RES_HOLD;
					ctl.cnt_op   = CNT_DEC;
					state_d      = S_IDLE;
				end
			end
			S_RD_OUT: begin
				if (st.out_free) begin
					ctl.res_load = 1'b1;
					ctl.res_src  = RES_RDATA;
					state_d      = S_IDLE;
				end
			end
			S_DMP_OUT: begin
				if (st.out_free) begin
					ctl.res_load = 1'b1;
					ctl.res_src  = RES_RDATA;
					ctl.res_last = st.dump_last;
					if (st.dump_last) begin
						state_d = S_IDLE;
					end else begin
						ctl.idx_op = IDX_INC;
						ctl.rd_en  = 1'b1;
					end
				end
			end
			S_ERR_FULL: begin
				if (st.out_free) begin
					ctl.res_load   = 1'b1;
					ctl.res_status = STAT_FULL;
					state_d        = S_IDLE;
				end
			end
			S_ERR_EMPTY: begin
				if (st.out_free) begin
					ctl.res_load   = 1'b1;
					ctl.res_status = STAT_EMPTY;
					state_d        = S_IDLE;
				end
			end
			S_ERR_NFND: begin
				if (st.out_free) begin
					ctl.res_load   = 1'b1;
					ctl.res_status = STAT_NOTFOUND;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[hdl/spt_dp.sv]
// ----------------------------------------------------------------------------
// Sorted price table datapath
// Entry RAM, index and count registers, price compare and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spt_dp
	import spt_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  spt_ctl_t                  ctl,
	output spt_stat_t                 st,
	input  logic [CMD_W-1:0]          cmd,
	input  logic [TAG_W-1:0]          tag,
	input  logic signed [PRICE_W-1:0] price,
	input  logic [POS_W-1:0]          position,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [STATUS_W-1:0]       status,
	output logic [TAG_W-1:0]          out_tag,
	output logic signed [PRICE_W-1:0] out_price,
	output logic [POS_W-1:0]          out_position,
	output logic                      last
);

	// latched item
	cmd_t                      cmd_q;
	logic [TAG_W-1:0]          tag_q;
	logic signed [PRICE_W-1:0] price_q;
	logic [POS_W-1:0]          pos_q;

	logic [IDX_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] count_q;

	logic [TAG_W-1:0]          hold_tag_q;
	logic signed [PRICE_W-1:0] hold_price_q;

	logic                      out_valid_q;
	logic [STATUS_W-1:0]       status_q;
	logic [TAG_W-1:0]          out_tag_q;
	logic signed [PRICE_W-1:0] out_price_q;
	logic [POS_W-1:0]          out_pos_q;
	logic                      last_q;

	logic [IDX_W-1:0]          rd_addr, wr_addr;
	logic [ENTRY_W-1:0]        wr_data, rd_data;
	logic [TAG_W-1:0]          rd_tag;
	logic signed [PRICE_W-1:0] rd_price;

	logic [CMP_W:0] idx_p1_w, idx_p2_w, cnt_w, pos_w;

	always_ff @(posedge clk) begin
		if (ctl.cap_in) begin
			cmd_q   <= cmd_t'(cmd);
			tag_q   <= tag;
			price_q <= price;
			pos_q   <= position;
		end
		if (ctl.hold_cap) begin
			hold_tag_q   <= rd_tag;
			hold_price_q <= rd_price;
		end
	end

	always_comb begin
		case (ctl.idx_op)
			IDX_HOLD: idx_d = idx_q;
			IDX_ZERO: idx_d = '0;
			IDX_TOP:  idx_d = IDX_W'(count_q - CNT_W'(1));
			IDX_POS:  idx_d = IDX_W'(pos_q);
			IDX_INC:  idx_d = idx_q + IDX_W'(1);
			IDX_DEC:  idx_d = idx_q - IDX_W'(1);
			default:  idx_d = idx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			idx_q <= idx_d;
			case (ctl.cnt_op)
				CNT_INC: count_q <= count_q + CNT_W'(1);
				CNT_DEC: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_addr = ctl.rd_p1 ? idx_d + IDX_W'(1) : idx_d;
	assign wr_addr = ctl.wr_p1 ? idx_q + IDX_W'(1) : idx_q;
	assign wr_data = ctl.wr_new ? {tag_q, price_q} : rd_data;

	spt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ctl.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (ctl.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_tag   = rd_data[ENTRY_W-1 -: TAG_W];
	assign rd_price = rd_data[PRICE_W-1:0];

	assign idx_p1_w = (CMP_W + 1)'(idx_q) + (CMP_W + 1)'(1);
	assign idx_p2_w = (CMP_W + 1)'(idx_q) + (CMP_W + 1)'(2);
	assign cnt_w    = (CMP_W + 1)'(count_q);
	assign pos_w    = (CMP_W + 1)'(pos_q);

	assign st.cmd       = cmd_q;
	assign st.cnt_zero  = (count_q == '0);
	assign st.cnt_full  = (count_q == CNT_W'(DEPTH));
	assign st.pos_oob   = (pos_w >= cnt_w);
	assign st.ge        = (rd_price >= price_q);
	assign st.idx_zero  = (idx_q == '0);
	assign st.del_tail  = (idx_p1_w >= cnt_w);
	assign st.del_more  = (idx_p2_w < cnt_w);
	// a dump stops at the table end or after MAX_RESULTS items
	assign st.dump_last = (idx_p1_w == cnt_w) || (idx_p1_w == (CMP_W + 1)'(MAX_RESULTS));
	assign st.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			status_q <= ctl.res_status;
			last_q   <= ctl.res_last;
			case (ctl.res_src)
				RES_NEW: begin
					out_tag_q   <= tag_q;
					out_price_q <= price_q;
					out_pos_q   <= POS_W'(idx_q);
				end
				RES_HOLD: begin
					out_tag_q   <= hold_tag_q;
					out_price_q <= hold_price_q;
					out_pos_q   <= pos_q;
				end
				RES_RDATA: begin
					out_tag_q   <= rd_tag;
					out_price_q <= rd_price;
					out_pos_q   <= POS_W'(idx_q);
				end
				default: begin
					out_tag_q   <= '0;
					out_price_q <= '0;
					out_pos_q   <= '0;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_tag      = out_tag_q;
	assign out_price    = out_price_q;
	assign out_position = out_pos_q;
	assign last         = last_q;

endmodule

[hdl/sorted_price_table_unit.sv]
// ----------------------------------------------------------------------------
// Sorted price table unit
// Table of (tag, price) entries kept in ascending signed price order.
// ----------------------------------------------------------------------------
// One item is handled at a time; the next is taken once the previous item's
// final result sits in the output register. Entries live in a single-port-
// read RAM and are moved one per cycle, so time per item is set by that
// port: an insert walks down past the entries priced at or above the new
// one, a delete shifts the entries behind the removed one and a dump emits
// its entries one by one; results also wait while the output side stalls.
// The worst case is a delete at the front of a full table. Commands 5 to 7
// are dropped with no result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_price_table_unit
	import spt_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [CMD_W-1:0]          cmd,
	input  logic [TAG_W-1:0]          tag,
	input  logic signed [PRICE_W-1:0] price,
	input  logic [POS_W-1:0]          position,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [STATUS_W-1:0]       status,
	output logic [TAG_W-1:0]          out_tag,
	output logic signed [PRICE_W-1:0] out_price,
	output logic [POS_W-1:0]          out_position,
	output logic                      last
);

	spt_ctl_t  ctl;
	spt_stat_t st;

	spt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.st      (st),
		.ctl     (ctl)
	);

	spt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.st          (st),
		.cmd         (cmd),
		.tag         (tag),
		.price       (price),
		.position    (position),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.out_tag     (out_tag),
		.out_price   (out_price),
		.out_position(out_position),
		.last        (last)
	);

endmodule

[hdl/spt_chk.sv]
// ----------------------------------------------------------------------------
// Sorted price table checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_price_table_unit_macros.svh"

module spt_chk
	import spt_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [STATUS_W-1:0]       status,
	input logic [TAG_W-1:0]          out_tag,
	input logic signed [PRICE_W-1:0] out_price,
	input logic [POS_W-1:0]          out_position,
	input logic                      last
);

	// error results close their item and carry no entry
	`SPT_ASSERT(a_err_last, out_valid && (status != STAT_OK) |-> last, "error result not last")
	`SPT_ASSERT(a_err_zero, out_valid && (status != STAT_OK) |-> (out_tag == '0) && (out_price == '0) && (out_position == '0), "error result carries data")

	// a dump in progress keeps the input closed
	`SPT_ASSERT(a_dump_busy, out_valid && !last |-> !in_ready, "item taken during dump")

	`SPT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_tag) && $stable(out_price) && $stable(status) && $stable(last), "stalled result changed")

	`SPT_ASSERT_RST(a_rst_out, !arst_n |-> !out_valid, "result valid in reset")

endmodule

bind sorted_price_table_unit spt_chk u_chk (.*);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Sorted price table unit testbench
// Drives insert, delete, read and dump commands through the valid/ready
// input channel and checks every result against a local sorted-table
// predictor. A short directed table comes first, followed by random
// fill/drain sequences. Input bursts and output stalls vary over the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import spt_pkg::*;

	localparam int CYCLE_LIMIT      = 200000;
	localparam int RANDOM_ITEMS     = 100;
	localparam int SETTLE_CYCLES    = 4 * DEPTH;
	localparam int REPORT_LIMIT     = 10;
	localparam int CMD_UNUSED_FIRST = CMD_DUMP + 1;
	localparam int CMD_UNUSED_LAST  = (1 << CMD_W) - 1;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TAG_W-1:0]    tag;
		logic [PRICE_W-1:0]  price;
		logic [POS_W-1:0]    pos;
		logic                last;
	} price_result_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [TAG_W-1:0]   tag;
		logic [PRICE_W-1:0] price;
		logic [POS_W-1:0]   pos;
		logic               pinned;
		price_result_t      exp;
	} stim_row_t;

	typedef enum {PH_FILL, PH_FULL_PROBE, PH_DRAIN, PH_EMPTY_PROBE, PH_MIX} stim_phase_t;
	typedef enum {RX_OPEN, RX_RANDOM, RX_STALLS} rx_mode_t;

	localparam price_result_t NO_PIN    = '0;
	localparam price_result_t EMPTY_RES = '{STAT_EMPTY, 16'h0, 32'h0, 4'h0, 1'b1};
	localparam price_result_t NFND_RES  = '{STAT_NOTFOUND, 16'h0, 32'h0, 4'h0, 1'b1};

	localparam int DIRECTED_ROWS = 23;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{CMD_DUMP,   16'h0000, 32'h0000_0000, 4'h0, 1'b1, EMPTY_RES},
		'{CMD_MIN,    16'h0000, 32'h0000_0000, 4'h0, 1'b1, EMPTY_RES},
		'{CMD_MAX,    16'h0000, 32'h0000_0000, 4'h0, 1'b1, EMPTY_RES},
		'{CMD_DELETE, 16'h0000, 32'h0000_0000, 4'hF, 1'b1, EMPTY_RES},
		'{CMD_INSERT, 16'hFFFF, 32'h7FFF_FFFF, 4'h0, 1'b1,
			'{STAT_OK, 16'hFFFF, 32'h7FFF_FFFF, 4'h0, 1'b1}},
		'{CMD_INSERT, 16'h0000, 32'h8000_0000, 4'h0, 1'b1,
			'{STAT_OK, 16'h0000, 32'h8000_0000, 4'h0, 1'b1}},
		'{CMD_INSERT, 16'h1234, 32'h0000_0000, 4'h0, 1'b0, NO_PIN},
		// equal price lands ahead of the stored one
		'{CMD_INSERT, 16'hA5A5, 32'h0000_0000, 4'h0, 1'b0, NO_PIN},
		'{CMD_INSERT, 16'h5A5A, 32'hFFFF_FFFF, 4'h0, 1'b0, NO_PIN},
		'{CMD_UNUSED_FIRST,     16'hBEEF, 32'h1111_1111, 4'h1, 1'b0, NO_PIN},
		'{CMD_UNUSED_FIRST + 1, 16'hBEEF, 32'h2222_2222, 4'h2, 1'b0, NO_PIN},
		'{CMD_UNUSED_LAST,      16'hBEEF, 32'h3333_3333, 4'h3, 1'b0, NO_PIN},
		'{CMD_MIN,    16'h0000, 32'h0000_0000, 4'h0, 1'b1,
			'{STAT_OK, 16'h0000, 32'h8000_0000, 4'h0, 1'b1}},
		'{CMD_MAX,    16'h0000, 32'h0000_0000, 4'h0, 1'b1,
			'{STAT_OK, 16'hFFFF, 32'h7FFF_FFFF, 4'h4, 1'b1}},
		'{CMD_DELETE, 16'h0000, 32'h0000_0000, 4'h5, 1'b1, NFND_RES},
		'{CMD_DELETE, 16'h0000, 32'h0000_0000, 4'hF, 1'b1, NFND_RES},
		'{CMD_DUMP,   16'h0000, 32'h0000_0000, 4'h0, 1'b0, NO_PIN},
		'{CMD_DELETE, 16'h0000, 32'h0000_0000, 4'h2, 1'b0, NO_PIN},
		'{CMD_DELETE, 16'h0000, 32'h0000_0000, 4'h0, 1'b1,
			'{STAT_OK, 16'h0000, 32'h8000_0000, 4'h0, 1'b1}},
		'{CMD_DELETE, 16'h0000, 32'h0000_0000, 4'h2, 1'b0, NO_PIN},
		'{CMD_INSERT, 16'h8000, 32'h7FFF_FFFF, 4'h0, 1'b0, NO_PIN},
		'{CMD_DUMP,   16'h0000, 32'h0000_0000, 4'h0, 1'b0, NO_PIN},
		'{CMD_MAX,    16'h0000, 32'h0000_0000, 4'h0, 1'b0, NO_PIN}
	};

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [CMD_W-1:0]          cmd;
	logic [TAG_W-1:0]          tag;
	logic signed [PRICE_W-1:0] price;
	logic [POS_W-1:0]          position;
	logic                      out_valid;
	logic                      out_ready;
	logic [STATUS_W-1:0]       status;
	logic [TAG_W-1:0]          out_tag;
	logic signed [PRICE_W-1:0] out_price;
	logic [POS_W-1:0]          out_position;
	logic                      last;

	// travels with the payload: typed-in expectation for directed rows
	logic          item_pinned;
	price_result_t item_exp;

	// predictor state
	logic [TAG_W-1:0]          shadow_tag   [DEPTH];
	logic signed [PRICE_W-1:0] shadow_price [DEPTH];
	int                        shadow_count = 0;
	price_result_t             price_expect_q [$];

	int est_count    = 0;
	int burst_left   = 0;
	int fault_count  = 0;
	int items_taken  = 0;
	int results_seen = 0;
	int full_seen    = 0;
	int empty_seen   = 0;
	int nfnd_seen    = 0;

	sorted_price_table_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.tag          (tag),
		.price        (price),
		.position     (position),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_tag      (out_tag),
		.out_price    (out_price),
		.out_position (out_position),
		.last         (last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Sorted-table predictor: applies one accepted item, queues its results.
	task automatic price_table_apply(input logic [CMD_W-1:0] c, input logic [TAG_W-1:0] t,
			input logic signed [PRICE_W-1:0] p, input logic [POS_W-1:0] at_pos);
		int            n;
		int            slot;
		int            i;
		int            m;
		price_result_t r;
		n = shadow_count;
		r = '0;
		r.last = 1'b1;
		if (c <= CMD_DUMP) begin
			if (c == CMD_INSERT) begin
				if (n >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					slot = 0;
					while (slot < n && shadow_price[slot] < p)
						slot++;
					for (i = n; i > slot; i--) begin
						shadow_tag[i]   = shadow_tag[i-1];
						shadow_price[i] = shadow_price[i-1];
					end
					shadow_tag[slot]   = t;
					shadow_price[slot] = p;
					shadow_count       = n + 1;
					r.status = STAT_OK;
					r.tag    = t;
					r.price  = p;
					r.pos    = POS_W'(slot);
				end
				price_expect_q.push_back(r);
			end else if (n == 0) begin
				r.status = STAT_EMPTY;
				price_expect_q.push_back(r);
			end else begin
				case (c)
					CMD_DELETE: begin
						if (int'(at_pos) >= n) begin
							r.status = STAT_NOTFOUND;
						end else begin
							r.status = STAT_OK;
							r.tag    = shadow_tag[at_pos];
							r.price  = shadow_price[at_pos];
							r.pos    = at_pos;
							for (i = at_pos; i + 1 < n; i++) begin
								shadow_tag[i]   = shadow_tag[i+1];
								shadow_price[i] = shadow_price[i+1];
							end
							shadow_count = n - 1;
						end
						price_expect_q.push_back(r);
					end
					CMD_MIN: begin
						r.status = STAT_OK;
						r.tag    = shadow_tag[0];
						r.price  = shadow_price[0];
						price_expect_q.push_back(r);
					end
					CMD_MAX: begin
						r.status = STAT_OK;
						r.tag    = shadow_tag[n-1];
						r.price  = shadow_price[n-1];
						r.pos    = POS_W'(n - 1);
						price_expect_q.push_back(r);
					end
					default: begin
						m = (n < MAX_RESULTS) ? n : MAX_RESULTS;
						for (i = 0; i < m; i++) begin
							r.status = STAT_OK;
							r.tag    = shadow_tag[i];
							r.price  = shadow_price[i];
							r.pos    = POS_W'(i);
							r.last   = (i == m - 1);
							price_expect_q.push_back(r);
						end
					end
				endcase
			end
		end
	endtask

	task automatic report_mismatch(input string what, input price_result_t want,
			input price_result_t got);
		fault_count++;
		if (fault_count <= REPORT_LIMIT)
			$display("%0t %s: exp st=%0d tag=%h price=%h pos=%0d last=%b | got st=%0d tag=%h price=%h pos=%0d last=%b",
				$time, what, want.status, want.tag, want.price, want.pos, want.last,
				got.status, got.tag, got.price, got.pos, got.last);
	endtask

	// Inputs and outputs are sampled at the edge, before any update lands.
	always @(posedge clk) begin : result_monitor
		price_result_t got;
		price_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{status, out_tag, out_price, out_position, last};
				results_seen++;
				if (got.status == STAT_FULL)
					full_seen++;
				if (got.status == STAT_EMPTY)
					empty_seen++;
				if (got.status == STAT_NOTFOUND)
					nfnd_seen++;
				if (price_expect_q.size() == 0) begin
					report_mismatch("unexpected result", '0, got);
				end else begin
					want = price_expect_q.pop_front();
					if (got.status !== want.status || got.tag !== want.tag ||
							got.price !== want.price || got.pos !== want.pos ||
							got.last !== want.last)
						report_mismatch("result mismatch", want, got);
				end
			end
			if (in_valid && in_ready) begin
				items_taken++;
				price_table_apply(cmd, tag, price, position);
				if (item_pinned)
					price_expect_q[price_expect_q.size()-1] = item_exp;
			end
		end
	end

	initial begin : ready_pattern
		rx_mode_t mode;
		int       mode_left;
		int       stall_left;
		mode       = RX_OPEN;
		mode_left  = 0;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(RX_OPEN, RX_STALLS));
				mode_left = $urandom_range(30, 90);
			end
			mode_left--;
			case (mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 6);
				default: begin
					if (stall_left > 0) begin
						out_ready <= 1'b0;
						stall_left--;
					end else begin
						out_ready <= 1'b1;
						if ($urandom_range(0, 3) == 0)
							stall_left = $urandom_range(1, 12);
					end
				end
			endcase
		end
	end

	// occupancy after an item; depends on occupancy, command and position only
	function automatic int count_after(input int n, input logic [CMD_W-1:0] c,
			input logic [POS_W-1:0] at_pos);
		if (c == CMD_INSERT && n < DEPTH)
			return n + 1;
		if (c == CMD_DELETE && n > 0 && int'(at_pos) < n)
			return n - 1;
		return n;
	endfunction

	function automatic logic signed [PRICE_W-1:0] rand_price();
		int roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2, 3, 4: return PRICE_W'($signed($urandom_range(0, 8)) - 4);
			default: return $urandom;
		endcase
	endfunction

	// Called right after an edge; returns at the accepting edge or after a gap.
	task automatic send_item(input logic [CMD_W-1:0] c, input logic [TAG_W-1:0] t,
			input logic signed [PRICE_W-1:0] p, input logic [POS_W-1:0] at_pos,
			input logic pin, input price_result_t pin_exp);
		int gap;
		in_valid    <= 1'b1;
		cmd         <= c;
		tag         <= t;
		price       <= p;
		position    <= at_pos;
		item_pinned <= pin;
		item_exp    <= pin_exp;
		do
			@(posedge clk);
		while (!in_ready);
		est_count = count_after(est_count, c, at_pos);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 25)
				: $urandom_range(0, 4);
		end else begin
			burst_left--;
		end
	endtask

	initial begin : stimulus
		stim_phase_t              phase;
		int                       probe_left;
		int                       live_items;
		int                       roll;
		logic [CMD_W-1:0]         c;
		logic [TAG_W-1:0]         t;
		logic signed [PRICE_W-1:0] p;
		logic [POS_W-1:0]         ps;

		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		cmd         <= CMD_INSERT;
		tag         <= '0;
		price       <= '0;
		position    <= '0;
		item_pinned <= 1'b0;
		item_exp    <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_item(DIRECTED[r].cmd, DIRECTED[r].tag, DIRECTED[r].price, DIRECTED[r].pos,
				DIRECTED[r].pinned, DIRECTED[r].exp);

		// random part: fill to full, probe, drain to empty, probe, mix; repeat
		phase      = PH_FILL;
		probe_left = 0;
		live_items = 0;
		while (live_items < RANDOM_ITEMS) begin
			c    = CMD_INSERT;
			t    = TAG_W'($urandom);
			p    = rand_price();
			ps   = POS_W'($urandom_range(0, 15));
			roll = $urandom_range(0, 99);
			case (phase)
				PH_FILL: begin
					if (roll < 75)
						c = CMD_INSERT;
					else if (roll < 85 && est_count > 0) begin
						c  = CMD_DELETE;
						ps = POS_W'($urandom_range(0, est_count - 1));
					end else
						c = CMD_W'($urandom_range(CMD_DELETE, CMD_UNUSED_LAST));
				end
				PH_FULL_PROBE: c = (probe_left > 1) ? CMD_INSERT : CMD_DUMP;
				PH_DRAIN: begin
					if (roll < 75 && est_count > 0) begin
						c  = CMD_DELETE;
						ps = POS_W'($urandom_range(0, est_count - 1));
					end else if (roll < 85)
						c = CMD_DELETE;
					else
						c = CMD_W'($urandom_range(CMD_MIN, CMD_DUMP));
				end
				PH_EMPTY_PROBE: c = CMD_W'($urandom_range(CMD_DELETE, CMD_DUMP));
				default: c = CMD_W'($urandom_range(CMD_INSERT, CMD_UNUSED_LAST));
			endcase
			send_item(c, t, p, ps, 1'b0, NO_PIN);
			if (c <= CMD_DUMP)
				live_items++;
			case (phase)
				PH_FILL: begin
					if (est_count == DEPTH) begin
						phase      = PH_FULL_PROBE;
						probe_left = 3;
					end
				end
				PH_FULL_PROBE: begin
					probe_left--;
					if (probe_left == 0)
						phase = PH_DRAIN;
				end
				PH_DRAIN: begin
					if (est_count == 0) begin
						phase      = PH_EMPTY_PROBE;
						probe_left = 2;
					end
				end
				PH_EMPTY_PROBE: begin
					probe_left--;
					if (probe_left == 0) begin
						phase      = PH_MIX;
						probe_left = $urandom_range(8, 16);
					end
				end
				default: begin
					probe_left--;
					if (probe_left == 0)
						phase = PH_FILL;
				end
			endcase
		end
		in_valid <= 1'b0;

		do
			@(posedge clk);
		while (price_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d items, checked %0d results", items_taken, results_seen);
		$display("Error results seen: %0d table full, %0d table empty, %0d bad position",
			full_seen, empty_seen, nfnd_seen);
		if (fault_count == 0 && price_expect_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d results still pending", cycles,
			price_expect_q.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
